@@ hdl/qce_pkg.sv @@
// Shared types and constants for the quadrature count extender with jump check.
// No dependencies; imported by every module of the block.
package qce_pkg;

    localparam int DATA_W     = 32;
    localparam int RAW_W      = 16;
    localparam int HIGH_W     = 16;
    localparam int JUMP_W     = 24;
    localparam int TAG_W      = 2;
    localparam int FUNC_W     = 2;
    localparam int CFG_AW     = 3;
    localparam int CFG_DW     = 32;

    // Stream payload widths, packed from bit 0 up.
    localparam int S_TDATA_W  = RAW_W + DATA_W;   // raw_count, preset_position
    localparam int M_TUSER_W  = 1 + TAG_W;        // jump_fault, fault_tag

    // Crossing windows for the high word.
    localparam logic [RAW_W-1:0] WRAP_UP_LIMIT   = 16'h1FFF;
    localparam logic [RAW_W-1:0] WRAP_DOWN_LIMIT = 16'hE000;

    localparam logic [JUMP_W-1:0] MAX_JUMP_RST = 24'd4096;

    // Register indexes on the configuration port.
    localparam logic [CFG_AW-3:0] REG_DIRECTION = 1'b0;
    localparam logic [CFG_AW-3:0] REG_MAX_JUMP  = 1'b1;

    // Update tags.
    localparam logic [TAG_W-1:0] TAG_NONE   = 2'd0;
    localparam logic [TAG_W-1:0] TAG_INIT   = 2'd1;
    localparam logic [TAG_W-1:0] TAG_PRESET = 2'd2;

    typedef enum logic [FUNC_W-1:0] {
        FUNC_SAMPLE = 2'd0,
        FUNC_INIT   = 2'd1,
        FUNC_PRESET = 2'd2
    } t_func;

    typedef struct packed {
        logic              reverse;
        logic [JUMP_W-1:0] max_jump;
    } t_cfg;

    typedef struct packed {
        logic [FUNC_W-1:0] func;
        logic [RAW_W-1:0]  raw_count;
        logic [DATA_W-1:0] preset_position;
    } t_item;

    typedef struct packed {
        logic [DATA_W-1:0] position;
        logic              jump_fault;
        logic [TAG_W-1:0]  fault_tag;
    } t_result;

endpackage

@@ hdl/qce_cfg_regs.sv @@
// Configuration registers behind the APB-style port.
// Depends on qce_pkg.
module qce_cfg_regs
    import qce_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [CFG_AW-1:0] paddr,
    input  logic [CFG_DW-1:0] pwdata,
    output logic [CFG_DW-1:0] prdata,
    output t_cfg              o_cfg
);

    logic              r_reverse;
    logic [JUMP_W-1:0] r_max_jump;
    logic              wr_en;
    logic [CFG_AW-3:0] reg_idx;

    assign reg_idx = paddr[CFG_AW-1:2];
    assign wr_en   = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_reverse  <= 1'b0;
            r_max_jump <= MAX_JUMP_RST;
        end else if (wr_en) begin
            case (reg_idx)
                REG_DIRECTION: r_reverse  <= pwdata[0];
                REG_MAX_JUMP:  r_max_jump <= pwdata[JUMP_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            REG_DIRECTION: prdata = {{(CFG_DW-1){1'b0}}, r_reverse};
            REG_MAX_JUMP:  prdata = {{(CFG_DW-JUMP_W){1'b0}}, r_max_jump};
            default:       prdata = '0;
        endcase
    end

    assign o_cfg.reverse  = r_reverse;
    assign o_cfg.max_jump = r_max_jump;

endmodule

@@ hdl/qce_update.sv @@
// Count extension, position update and jump check for one registered beat.
// Holds the running state; depends on qce_pkg.
module qce_update
    import qce_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_adv,
    input  t_item   i_item,
    input  t_cfg    i_cfg,
    output t_result o_result
);

    logic [RAW_W-1:0]  r_prev_raw, n_prev_raw;
    logic [HIGH_W-1:0] r_high,     n_high;
    logic [DATA_W-1:0] r_base,     n_base;
    logic [DATA_W-1:0] r_last,     n_last;
    logic [TAG_W-1:0]  r_tag,      n_tag;

    logic              now_neg, was_neg, cross_up, cross_dn;
    logic [HIGH_W-1:0] high_upd;
    logic [DATA_W-1:0] ext, pos, delta, mag;
    logic              fault;

    assign now_neg  = i_item.raw_count[RAW_W-1];
    assign was_neg  = r_prev_raw[RAW_W-1];
    assign cross_up = !now_neg && (i_item.raw_count < WRAP_UP_LIMIT) && was_neg;
    assign cross_dn = now_neg && (i_item.raw_count > WRAP_DOWN_LIMIT) && !was_neg;

    always_comb begin
        if (cross_up) begin
            high_upd = r_high + 1'b1;
        end else if (cross_dn) begin
            high_upd = r_high - 1'b1;
        end else begin
            high_upd = r_high;
        end
    end

    assign ext   = {high_upd, i_item.raw_count};
    assign pos   = i_cfg.reverse ? (r_base - ext) : (r_base + ext);
    // Shorter way round the 32-bit circle.
    assign delta = pos - r_last;
    assign mag   = delta[DATA_W-1] ? (~delta + 1'b1) : delta;
    assign fault = mag > {{(DATA_W-JUMP_W){1'b0}}, i_cfg.max_jump};

    always_comb begin
        n_prev_raw = r_prev_raw;
        n_high     = r_high;
        n_base     = r_base;
        n_last     = r_last;
        n_tag      = r_tag;
        o_result.jump_fault = 1'b0;
        case (t_func'(i_item.func))
            FUNC_SAMPLE: begin
                n_prev_raw = i_item.raw_count;
                n_high     = high_upd;
                n_last     = pos;
                o_result.jump_fault = fault;
            end
            FUNC_INIT, FUNC_PRESET: begin
                n_prev_raw = '0;
                n_high     = '0;
                n_base     = i_item.preset_position;
                n_last     = i_item.preset_position;
                n_tag      = (t_func'(i_item.func) == FUNC_INIT) ? TAG_INIT : TAG_PRESET;
            end
            default: ;  // unused code: leave state alone
        endcase
        o_result.position  = n_last;
        o_result.fault_tag = n_tag;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev_raw <= '0;
            r_high     <= '0;
            r_base     <= '0;
            r_last     <= '0;
            r_tag      <= TAG_NONE;
        end else if (i_adv) begin
            r_prev_raw <= n_prev_raw;
            r_high     <= n_high;
            r_base     <= n_base;
            r_last     <= n_last;
            r_tag      <= n_tag;
        end
    end

endmodule

@@ hdl/quadrature_count_extender_jump_check.sv @@
// Top level of the quadrature count extender with jump check.
// Depends on qce_pkg, qce_cfg_regs and qce_update.
//
//  channel      direction  handshake                     payload
//  s_axis       in         i_s_axis_tvalid/o_s_axis_tready  tdata: raw_count, preset_position
//                                                         tuser: func
//  m_axis       out        o_m_axis_tvalid/i_m_axis_tready  tdata: position
//                                                         tuser: jump_fault, fault_tag
//  apb          in/out     psel, penable, pready          direction_reverse @0, max_jump @4
//
// One beat per cycle sustained while the output is not stalled. A beat waits in the input
// register, where the extension, add and jump compare run against the running state, then
// lands in the output register.
// Reset is synchronous, active low; it clears both valid flags, the state and the
// registers (max_jump to 4096).
// A stalled output holds its beat while the input register keeps one more beat waiting.
module quadrature_count_extender_jump_check
    import qce_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,

    input  logic                 i_s_axis_tvalid,
    output logic                 o_s_axis_tready,
    input  logic [S_TDATA_W-1:0] i_s_axis_tdata,   // [15:0] raw_count, [47:16] preset_position
    input  logic [FUNC_W-1:0]    i_s_axis_tuser,   // [1:0] func

    output logic                 o_m_axis_tvalid,
    input  logic                 i_m_axis_tready,
    output logic [DATA_W-1:0]    o_m_axis_tdata,   // [31:0] position
    output logic [M_TUSER_W-1:0] o_m_axis_tuser,   // [0] jump_fault, [2:1] fault_tag

    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [CFG_AW-1:0]    paddr,
    input  logic [CFG_DW-1:0]    pwdata,
    output logic [CFG_DW-1:0]    prdata,
    output logic                 pready
);

    t_cfg    cfg;
    t_result result;
    t_item   r_item;
    t_result r_out;
    logic    r_in_vld;
    logic    r_out_vld;
    logic    adv;

    assign pready = 1'b1;

    qce_cfg_regs u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .o_cfg   (cfg)
    );

    // Advance the held beat whenever the output register is free or draining.
    assign adv             = r_in_vld && (!r_out_vld || i_m_axis_tready);
    assign o_s_axis_tready = !r_in_vld || adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (o_s_axis_tready) begin
            r_in_vld <= i_s_axis_tvalid;
        end
    end

    // Capture the input beat; payload needs no reset.
    always_ff @(posedge i_clk) begin
        if (o_s_axis_tready && i_s_axis_tvalid) begin
            r_item.func            <= i_s_axis_tuser;
            r_item.raw_count       <= i_s_axis_tdata[RAW_W-1:0];
            r_item.preset_position <= i_s_axis_tdata[S_TDATA_W-1:RAW_W];
        end
    end

    qce_update u_update (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_adv    (adv),
        .i_item   (r_item),
        .i_cfg    (cfg),
        .o_result (result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (adv) begin
            r_out_vld <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_out <= result;
        end
    end

    assign o_m_axis_tvalid = r_out_vld;
    assign o_m_axis_tdata  = r_out.position;
    assign o_m_axis_tuser  = {r_out.fault_tag, r_out.jump_fault};

endmodule

@@ hdl/qce_checker.sv @@
// Port-level checks for quadrature_count_extender_jump_check, bound to the top level.
// Depends on qce_pkg.
module qce_port_checks
    import qce_pkg::*;
(
    input logic                 i_clk,
    input logic                 i_rst_n,
    input logic                 o_m_axis_tvalid,
    input logic                 i_m_axis_tready,
    input logic [DATA_W-1:0]    o_m_axis_tdata,
    input logic [M_TUSER_W-1:0] o_m_axis_tuser,
    input logic                 psel,
    input logic                 penable,
    input logic                 pwrite,
    input logic [CFG_AW-1:0]    paddr,
    input logic [CFG_DW-1:0]    pwdata,
    input logic [CFG_DW-1:0]    prdata
);

    // Hold a stalled output beat.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=>
            o_m_axis_tvalid && $stable(o_m_axis_tdata) && $stable(o_m_axis_tuser))
        else $error("output beat changed while stalled");

    // Drop valid out of reset.
    a_rst_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_axis_tvalid)
        else $error("output valid right after reset");

    // The tag never carries the unused code.
    a_tag_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> (o_m_axis_tuser[M_TUSER_W-1:1] == TAG_NONE ||
                             o_m_axis_tuser[M_TUSER_W-1:1] == TAG_INIT ||
                             o_m_axis_tuser[M_TUSER_W-1:1] == TAG_PRESET))
        else $error("fault tag out of range");

    // A max_jump write reads back on the next cycle.
    a_jump_readback: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        psel && penable && pwrite && paddr[2] ##1 psel && !pwrite && paddr[2] |->
            prdata == {{(CFG_DW-JUMP_W){1'b0}}, $past(pwdata[JUMP_W-1:0])})
        else $error("max_jump readback mismatch");

endmodule

bind quadrature_count_extender_jump_check qce_port_checks u_qce_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .o_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .o_m_axis_tdata  (o_m_axis_tdata),
    .o_m_axis_tuser  (o_m_axis_tuser),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata)
);
